// File: design/assert_macros.svh
// Assertion macros used by the checker module of the project.
// Holds macros only; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/smss_pkg.sv
// Shared types and constants of the substring match stream unit.
// Used by the window cell, the top level and the checker; depends on nothing.
package smss_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAT_W     = 64;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PIDX_W    = 4;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_PATTERN_LENGTH = 3'd2,
    CFG_START_POSITION = 3'd3,
    CFG_FIRST_ONLY     = 3'd4
  } cfg_index_e;

  // Per-cell control: shift on a transfer, clear after the last byte,
  // and whether the cell takes part in the compare.
  typedef struct packed {
    logic shift;
    logic clear;
    logic active;
  } cell_ctrl_t;

endpackage

// File: design/smss_cell.sv
// One cell of the sliding text window: holds one byte, passes it on.
// Depends on smss_pkg for the byte width and the control struct.
module smss_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smss_pkg::cell_ctrl_t           ctrl_i,
  input  logic [smss_pkg::BYTE_W-1:0]    data_i,
  input  logic [smss_pkg::BYTE_W-1:0]    pattern_i,
  output logic [smss_pkg::BYTE_W-1:0]    data_o,
  output logic                           eq_o
);

  logic [smss_pkg::BYTE_W-1:0] data_q, data_d;

  // The compare looks at the byte this cell takes in on the transfer, so it
  // sees the window as it stands after the shift.
  assign eq_o = !ctrl_i.active || (data_i == pattern_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = ctrl_i.clear ? '0 : data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: design/substring_match_stream_unit.sv
// A result is valid in the cycle after the input transfer that causes it.
// One text byte per cycle while the output is not stalled; the window cells shift and
// compare in the same cycle, and a new byte can enter in the cycle a held result is taken.
// Reset clears the window, the byte index and the seen flag, and sets the
// pattern to zero, the length to one, the start position to zero, first-only on.
module substring_match_stream_unit #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [smss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [smss_pkg::PAT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [smss_pkg::BYTE_W-1:0]       text_byte_i,
  input  logic                              last_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              match_found_o,
  output logic [smss_pkg::POS_W-1:0]        match_position_o,
  output logic                              end_of_text_o
);

  localparam int unsigned CMP_W = (INDEX_WIDTH > smss_pkg::POS_W) ?
                                  INDEX_WIDTH : smss_pkg::POS_W;
  localparam logic [smss_pkg::LEN_W-1:0] MAX_LEN = smss_pkg::LEN_W'(MAX_PATTERN);

  // Configuration registers.
  logic [smss_pkg::PAT_W-1:0]   pat_low_q, pat_high_q;
  logic [smss_pkg::LEN_W-1:0]   pat_len_q;
  logic [smss_pkg::POS_W-1:0]   start_pos_q;
  logic                         first_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q    <= '0;
      pat_high_q   <= '0;
      pat_len_q    <= smss_pkg::LEN_W'(1);
      start_pos_q  <= '0;
      first_only_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        smss_pkg::CFG_PATTERN_LOW:    pat_low_q    <= cfg_wdata_i;
        smss_pkg::CFG_PATTERN_HIGH:   pat_high_q   <= cfg_wdata_i;
        smss_pkg::CFG_PATTERN_LENGTH: pat_len_q    <= cfg_wdata_i[smss_pkg::LEN_W-1:0];
        smss_pkg::CFG_START_POSITION: start_pos_q  <= cfg_wdata_i[smss_pkg::POS_W-1:0];
        smss_pkg::CFG_FIRST_ONLY:     first_only_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Length in use, clamped to one at the bottom and the window size on top.
  logic [smss_pkg::LEN_W-1:0] len_w;
  always_comb begin
    len_w = pat_len_q;
    if (pat_len_q == '0) begin
      len_w = smss_pkg::LEN_W'(1);
    end else if (pat_len_q > MAX_LEN) begin
      len_w = MAX_LEN;
    end
  end

  logic [smss_pkg::BYTE_W-1:0] pat_bytes [smss_pkg::PAT_BYTES];
  always_comb begin
    for (int unsigned k = 0; k < smss_pkg::PAT_BYTES / 2; k++) begin
      pat_bytes[k]                          = pat_low_q[smss_pkg::BYTE_W*k +: smss_pkg::BYTE_W];
      pat_bytes[k + smss_pkg::PAT_BYTES/2]  = pat_high_q[smss_pkg::BYTE_W*k +: smss_pkg::BYTE_W];
    end
  end

  logic in_xfer;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Chain of window cells; cell 0 holds the newest byte.
  logic [smss_pkg::BYTE_W-1:0] cell_in  [MAX_PATTERN];
  logic [smss_pkg::BYTE_W-1:0] cell_out [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]      cell_eq;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    smss_pkg::cell_ctrl_t            ctrl;
    logic [smss_pkg::LEN_W-1:0]      pidx;

    // Cell j faces pattern byte (length - 1 - j).
    assign pidx        = len_w - smss_pkg::LEN_W'(j) - smss_pkg::LEN_W'(1);
    assign ctrl.shift  = in_xfer;
    assign ctrl.clear  = last_byte_i;
    assign ctrl.active = smss_pkg::LEN_W'(j) < len_w;

    if (j == 0) begin : g_head
      assign cell_in[j] = text_byte_i;
    end else begin : g_link
      assign cell_in[j] = cell_out[j-1];
    end

    smss_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .data_i    (cell_in[j]),
      .pattern_i (pat_bytes[pidx[smss_pkg::PIDX_W-1:0]]),
      .data_o    (cell_out[j]),
      .eq_o      (cell_eq[j])
    );
  end

  // Byte index and match decision.
  logic [INDEX_WIDTH-1:0] idx_q, idx_d;
  logic                   seen_q, seen_d;
  logic [INDEX_WIDTH:0]   cur_plus1, pos_full;
  logic [INDEX_WIDTH-1:0] pos;
  logic                   enough, hit, report;

  assign cur_plus1 = {1'b0, idx_q} + (INDEX_WIDTH+1)'(1);
  assign enough    = cur_plus1 >= (INDEX_WIDTH+1)'(len_w);
  assign pos_full  = cur_plus1 - (INDEX_WIDTH+1)'(len_w);
  assign pos       = pos_full[INDEX_WIDTH-1:0];
  assign hit       = enough && (&cell_eq) && (CMP_W'(pos) >= CMP_W'(start_pos_q));
  assign report    = hit && !(first_only_q && seen_q);

  always_comb begin
    idx_d  = idx_q;
    seen_d = seen_q;
    if (in_xfer) begin
      if (last_byte_i) begin
        idx_d  = '0;
        seen_d = 1'b0;
      end else begin
        if (idx_q != '1) begin
          idx_d = idx_q + INDEX_WIDTH'(1);
        end
        seen_d = seen_q || hit;
      end
    end
  end

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic                        found_q, found_d;
  logic [smss_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                        eot_q, eot_d;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    pos_d       = pos_q;
    eot_d       = eot_q;
    if (in_xfer && (last_byte_i || report)) begin
      out_valid_d = 1'b1;
      found_d     = last_byte_i ? (seen_q || hit) : 1'b1;
      pos_d       = report ? smss_pkg::POS_W'(pos) : '0;
      eot_d       = last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pos_q   <= pos_d;
    eot_q   <= eot_d;
  end

  assign out_valid_o      = out_valid_q;
  assign match_found_o    = found_q;
  assign match_position_o = pos_q;
  assign end_of_text_o    = eot_q;

endmodule

// File: design/smss_checker.sv
// Port-level checks of the substring match stream unit, bound to the top level.
// Depends on assert_macros.svh and smss_pkg.
`include "assert_macros.svh"

module smss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           last_byte_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           match_found_o,
  input logic [smss_pkg::POS_W-1:0]     match_position_o,
  input logic                           end_of_text_o
);

  // A result that waits keeps its payload.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_found_o) && $stable(match_position_o) && $stable(end_of_text_o), "stalled result changed")

  // The last byte of a text always yields an end result in the next cycle.
  `ASSERT_CLK(a_end_follows, clk_i, rst_ni, in_valid_i && in_ready_o && last_byte_i |=> out_valid_o && end_of_text_o, "missing end-of-text result")

  // A result before the end of the text always reports a match.
  `ASSERT_CLK(a_mid_is_match, clk_i, rst_ni, out_valid_o && !end_of_text_o |-> match_found_o, "result without a match")

  // An end result with nothing found carries position zero.
  `ASSERT_CLK(a_none_pos_zero, clk_i, rst_ni, out_valid_o && !match_found_o |-> match_position_o == '0, "position set without a match")

endmodule

bind substring_match_stream_unit smss_checker u_smss_checker (.*);
